@@ src/lpfp_pkg.sv @@
`timescale 1ns / 1ps

package lpfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 12;
  localparam int unsigned OutDataW = 24;

  localparam logic [LenW-1:0] MaxPayloadReset = 12'hFFF;
  localparam logic [3:0]      LenHiMask       = 4'hF;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_HDR2 = 3'd2,
    PH_HDR3 = 3'd3,
    PH_PAY  = 3'd4,
    PH_CHK0 = 3'd5,
    PH_CHK1 = 3'd6
  } phase_t;

  typedef enum logic {
    KIND_PAYLOAD   = 1'b0,
    KIND_FRAME_END = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ByteW-1:0]  data;
    logic [LenW-1:0]   payload_length;
  } result_t;

endpackage

@@ src/length_prefixed_frame_parser_unit.sv @@
`timescale 1ns / 1ps

// Length-prefixed frame parser.
// The slave stream takes one received link byte per word. Each frame is a
// four-byte header, a payload and two check bytes; the payload length is the
// low nibble of header byte 1 times 256 plus header byte 2. Sync and check
// bytes are consumed without being checked. The master stream carries one
// result word per payload byte passed on (tuser 0) and one frame-end word on
// the second check byte (tuser 1, with the full header length in tdata).
// Payload bytes beyond max_payload are consumed and produce no word.
// Throughput is one byte per cycle while s_axis_tready is high: the parser
// state updates in the cycle a byte is accepted, and its result is registered
// in the output register, or in the skid register behind it if the output
// word is held, so tready stays high for one more result word while the
// receiver stalls; with both full, tready drops until the receiver takes a word.
// The config channel is always ready; a written max_payload takes effect for
// the bytes that follow. Reset (synchronous) returns the parser to header
// byte zero, sets max_payload to 4095 and empties both result registers.
module length_prefixed_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data, [19:8] payload_length, [23:20] zero
  output logic        m_axis_tuser,   // [0] kind: 0 payload byte, 1 end of frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data        // [11:0] max_payload
);
  import lpfp_pkg::*;

  phase_t          phase, phase_next;
  logic [LenW-1:0] frame_length, frame_length_next;
  logic [LenW-1:0] byte_count, byte_count_next;
  logic [LenW-1:0] max_payload;

  result_t out_word, out_word_next;
  logic    out_valid, out_valid_next;
  result_t skid_word, skid_word_next;
  logic    skid_valid, skid_valid_next;

  result_t         res;
  logic            res_valid;
  logic            accept;
  logic            pop;
  logic [LenW-1:0] count_inc;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid && m_axis_tready;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_word.kind;
  assign m_axis_tdata  = {{(OutDataW - LenW - ByteW){1'b0}},
                          out_word.payload_length, out_word.data};

  assign count_inc = byte_count + {{(LenW-1){1'b0}}, 1'b1};

  // Parser step for the byte on the slave side.
  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    byte_count_next   = byte_count;
    res               = '{kind: KIND_PAYLOAD, data: '0, payload_length: '0};
    res_valid         = 1'b0;
    case (phase)
      PH_HDR1: begin
        frame_length_next = {s_axis_tdata[3:0] & LenHiMask, {ByteW{1'b0}}};
        phase_next        = PH_HDR2;
      end
      PH_HDR2: begin
        frame_length_next = frame_length | {{(LenW-ByteW){1'b0}}, s_axis_tdata};
        phase_next        = PH_HDR3;
      end
      PH_HDR3: begin
        byte_count_next = '0;
        phase_next      = (frame_length == '0) ? PH_CHK0 : PH_PAY;
      end
      PH_PAY: begin
        if (byte_count < max_payload) begin
          res.data  = s_axis_tdata;
          res_valid = 1'b1;
        end
        byte_count_next = count_inc;
        if (count_inc >= frame_length) begin
          phase_next = PH_CHK0;
        end
      end
      PH_CHK0: begin
        phase_next = PH_CHK1;
      end
      PH_CHK1: begin
        res.kind           = KIND_FRAME_END;
        res.payload_length = frame_length;
        res_valid          = 1'b1;
        phase_next         = PH_HDR0;
      end
      default: begin
        phase_next = PH_HDR1;
      end
    endcase
  end

  // Output register with a skid register behind it.
  always_comb begin
    out_word_next   = out_word;
    out_valid_next  = out_valid;
    skid_word_next  = skid_word;
    skid_valid_next = skid_valid;
    if (pop) begin
      if (skid_valid) begin
        out_word_next   = skid_word;
        skid_valid_next = 1'b0;
      end else begin
        out_valid_next = 1'b0;
      end
    end
    if (accept && res_valid) begin
      if (!out_valid || (pop && !skid_valid)) begin
        out_word_next  = res;
        out_valid_next = 1'b1;
      end else begin
        skid_word_next  = res;
        skid_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      frame_length <= '0;
      byte_count   <= '0;
      max_payload  <= MaxPayloadReset;
      out_valid    <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        frame_length <= frame_length_next;
        byte_count   <= byte_count_next;
      end
      if (cfg_valid && cfg_ready) begin
        max_payload <= cfg_data;
      end
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_word  <= out_word_next;
    skid_word <= skid_word_next;
  end

  // The skid register only fills behind a held output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a word while the output is empty");

  // A frame-end word never carries payload data.
  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("frame-end word with nonzero data");

  // A payload word never carries a length.
  a_payload_no_len: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[23:8] == 16'h0000))
    else $error("payload word with nonzero length field");

  // Inside the payload the count stays below the header length.
  a_count_in_frame: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY) |-> (byte_count < frame_length))
    else $error("payload byte count ran past the frame length");

  // A payload word only comes from a byte accepted in the payload phase.
  a_payload_source: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && res.kind == KIND_PAYLOAD) |-> (phase == PH_PAY))
    else $error("payload word produced outside the payload phase");

endmodule
